@@ rtl/bits_to_hashed_grid_centers_top_assert.svh @@
// assertion macros for the bits to hashed grid centers block
`ifndef BITS_TO_HASHED_GRID_CENTERS_TOP_ASSERT_SVH
`define BITS_TO_HASHED_GRID_CENTERS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define B2H_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("b2hgc assertion failed");
`define B2H_NEVER(lbl, cond) `B2H_ASSERT(lbl, !(cond))
`else
`define B2H_ASSERT(lbl, prop)
`define B2H_NEVER(lbl, cond)
`endif
`endif

@@ rtl/b2hgc_pkg.sv @@
// package: constants, command and status types for the grid centers block
`default_nettype none
package b2hgc_pkg;
	localparam int B2H_MAX_CELLS_DEF = 4096;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CW    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IRREG = 3'd4;

	localparam logic [12:0] RST_COLS = 13'd64;
	localparam logic [12:0] RST_ROWS = 13'd64;
	localparam logic [15:0] RST_CW   = 16'd256;
	localparam logic [15:0] RST_CH   = 16'd256;

	localparam int CELL_W  = 12;
	localparam int COORD_W = 28;

	localparam logic [31:0] HASH_C1 = 32'd374761393;
	localparam logic [31:0] HASH_C2 = 32'd668265263;
	localparam logic [31:0] HASH_C3 = 32'd1274126177;
	localparam logic [31:0] SALT_X  = HASH_C3;
	localparam logic [31:0] SALT_Y  = 32'd2548252354;

	localparam logic [15:0] OFF_MID   = 16'd32768;
	localparam logic [15:0] OFF_BASE  = 16'd26214;
	localparam logic [33:0] OFF_SCALE = 34'd13107;

	typedef struct packed {
		logic acc;
		logic rd;
		logic div_start;
		logic div_step;
		logic ha;
		logic hb;
		logic hc;
		logic hd;
		logic pl;
		logic axis_y;
		logic emit;
	} b2h_cmd_t;

	typedef struct packed {
		logic has_hit;
		logic last_hit;
		logic div_last;
	} b2h_stat_t;
endpackage
`default_nettype wire

@@ rtl/b2hgc_if.sv @@
// input and output channel interfaces
`default_nettype none
interface b2hgc_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [11:0] perm_address;
	logic [11:0] perm_value;
	logic [7:0]  data_byte;
	logic        final_byte;
	modport source (output valid, mode, perm_address, perm_value, data_byte, final_byte,
		input ready);
	modport sink (input valid, mode, perm_address, perm_value, data_byte, final_byte,
		output ready);
endinterface

interface b2hgc_out_if;
	logic        valid;
	logic        ready;
	logic [27:0] centre_x;
	logic [27:0] centre_y;
	logic [11:0] cell_column;
	logic [11:0] cell_row;
	logic        run_end;
	modport source (output valid, centre_x, centre_y, cell_column, cell_row, run_end,
		input ready);
	modport sink (input valid, centre_x, centre_y, cell_column, cell_row, run_end,
		output ready);
endinterface
`default_nettype wire

@@ rtl/bits_to_hashed_grid_centers_top.sv @@
// top level of the bits to hashed grid centers block
// usage:
//  in_ch carries one transaction per item: mode 0 writes a permutation
//  entry (the block stays idle), mode 1 delivers a message byte, MSB first.
//  each set bit at an index inside both the grid and the table yields one
//  transaction on out_ch with the cell centre, its column and row; run_end
//  marks the last one of a byte. per emitted centre a byte takes one
//  memory read, a restoring divide by the column count and a sequence
//  of single multiplies for the hash and the placement.
//  in_ch.ready is high only while no byte is in work.
//  the output register frees the controller while a result waits; if the
//  receiver stalls the next result holds until out_ch.ready.
//  config writes go through cfg_we, cfg_index, cfg_data while idle.
//  reset clears the byte position, config takes its defaults, the
//  permutation memory holds no defined values until written.
`default_nettype none
`include "bits_to_hashed_grid_centers_top_assert.svh"
module bits_to_hashed_grid_centers_top
	import b2hgc_pkg::*;
#(
	parameter int MAX_CELLS = B2H_MAX_CELLS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	b2hgc_in_if.sink                   in_ch,
	b2hgc_out_if.source                out_ch
);
	b2h_cmd_t  cmd;
	b2h_stat_t stat;

	b2hgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_mode   (in_ch.mode),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	b2hgc_dp #(.MAX_CELLS(MAX_CELLS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_mode         (in_ch.mode),
		.in_perm_address (in_ch.perm_address),
		.in_perm_value   (in_ch.perm_value),
		.in_data_byte    (in_ch.data_byte),
		.in_final_byte   (in_ch.final_byte),
		.cmd             (cmd),
		.stat            (stat),
		.centre_x        (out_ch.centre_x),
		.centre_y        (out_ch.centre_y),
		.cell_column     (out_ch.cell_column),
		.cell_row        (out_ch.cell_row),
		.run_end         (out_ch.run_end)
	);

	`B2H_ASSERT(a_byte_blocks, in_ch.valid && in_ch.ready && in_ch.mode |=> !in_ch.ready)
	`B2H_NEVER(a_no_overrun, cmd.emit && out_ch.valid && !out_ch.ready)
	`B2H_NEVER(a_emit_needs_hit, cmd.emit && !stat.has_hit)
endmodule
`default_nettype wire

@@ rtl/b2hgc_ctrl.sv @@
// controller state machine sequencing one set bit at a time
`default_nettype none
module b2hgc_ctrl
	import b2hgc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_mode,
	output logic           in_ready,
	input  wire logic      out_ready,
	output logic           out_valid,
	input  wire b2h_stat_t stat,
	output b2h_cmd_t       cmd
);
	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_CHK  = 14'b00000000000010,
		S_RD   = 14'b00000000000100,
		S_RDW  = 14'b00000000001000,
		S_DIV  = 14'b00000000010000,
		S_HA   = 14'b00000000100000,
		S_HB   = 14'b00000001000000,
		S_HCX  = 14'b00000010000000,
		S_HDX  = 14'b00000100000000,
		S_PLX  = 14'b00001000000000,
		S_HCY  = 14'b00010000000000,
		S_HDY  = 14'b00100000000000,
		S_PLY  = 14'b01000000000000,
		S_EMIT = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   can_load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign can_load  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.acc = in_valid;
				if (in_valid && in_mode) state_d = S_CHK;
			end
			S_CHK: state_d = stat.has_hit ? S_RD : S_IDLE;
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_RDW;
			end
			S_RDW: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = S_HA;
			end
			S_HA: begin
				cmd.ha  = 1'b1;
				state_d = S_HB;
			end
			S_HB: begin
				cmd.hb  = 1'b1;
				state_d = S_HCX;
			end
			S_HCX: begin
				cmd.hc  = 1'b1;
				state_d = S_HDX;
			end
			S_HDX: begin
				cmd.hd  = 1'b1;
				state_d = S_PLX;
			end
			S_PLX: begin
				cmd.pl  = 1'b1;
				state_d = S_HCY;
			end
			S_HCY: begin
				cmd.hc     = 1'b1;
				cmd.axis_y = 1'b1;
				state_d    = S_HDY;
			end
			S_HDY: begin
				cmd.hd     = 1'b1;
				cmd.axis_y = 1'b1;
				state_d    = S_PLY;
			end
			S_PLY: begin
				cmd.pl     = 1'b1;
				cmd.axis_y = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (can_load) begin
					cmd.emit = 1'b1;
					state_d  = stat.last_hit ? S_IDLE : S_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

@@ rtl/b2hgc_dp.sv @@
// datapath: config registers, permutation memory, divider, hash and placement
`default_nettype none
module b2hgc_dp
	import b2hgc_pkg::*;
#(
	parameter int MAX_CELLS = B2H_MAX_CELLS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_mode,
	input  wire logic [11:0]           in_perm_address,
	input  wire logic [11:0]           in_perm_value,
	input  wire logic [7:0]            in_data_byte,
	input  wire logic                  in_final_byte,
	input  wire b2h_cmd_t              cmd,
	output b2h_stat_t                  stat,
	output logic [COORD_W-1:0]         centre_x,
	output logic [COORD_W-1:0]         centre_y,
	output logic [CELL_W-1:0]          cell_column,
	output logic [CELL_W-1:0]          cell_row,
	output logic                       run_end
);
	localparam int POS_LIMIT = (MAX_CELLS + 7) / 8;
	localparam int PW        = $clog2(POS_LIMIT + 1);
	localparam int IW        = PW + 3;
	localparam int AW        = $clog2(MAX_CELLS);
	localparam int PRODW     = 26;
	localparam int CMPW      = (IW > PRODW) ? IW : PRODW;
	localparam logic [3:0] DIV_STEPS = 4'(CELL_W);

	logic [12:0]      cols_q, rows_q;
	logic [15:0]      cw_q, ch_q;
	logic             irr_q;
	logic [PRODW-1:0] prod;
	logic [PW-1:0]    pos_q, pos_cap_q;
	logic [7:0]       hits_q, hits_d;
	logic [3:0]       div_cnt_q;
	logic [2:0]       cur_b;
	logic [IW-1:0]    idx_b;

	logic [CELL_W-1:0] mem [MAX_CELLS];
	logic [CELL_W-1:0] rd_q;
	logic [12:0]       rem_q;
	logic [CELL_W-1:0] quo_q;
	logic [13:0]       shifted;
	logic              ge;
	logic [31:0]       ta_q, hm_q, ta_col, ta_row, ht, ht2, hm_d, hx;
	logic [33:0]       sc;
	logic [15:0]       off_q, off_d;
	logic [27:0]       q16;
	logic [43:0]       pp;
	logic [COORD_W-1:0] px_q, py_q;

	assign prod = PRODW'({13'b0, cols_q} * {13'b0, rows_q});

	// hit mask for the incoming byte
	always_comb begin
		logic [IW-1:0] ix;
		hits_d = '0;
		for (int b = 0; b < 8; b++) begin
			ix = {pos_q, 3'(b)};
			hits_d[b] = in_data_byte[7-b] && (CMPW'(ix) < CMPW'(prod))
				&& (int'(ix) < MAX_CELLS);
		end
	end

	always_comb begin
		cur_b = 3'd0;
		for (int b = 7; b >= 0; b--) begin
			if (hits_q[b]) cur_b = 3'(b);
		end
	end

	assign idx_b         = {pos_cap_q, cur_b};
	assign stat.has_hit  = |hits_q;
	assign stat.last_hit = (hits_q & (hits_q - 8'd1)) == 8'd0;
	assign stat.div_last = (div_cnt_q == 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q    <= RST_COLS;
			rows_q    <= RST_ROWS;
			cw_q      <= RST_CW;
			ch_q      <= RST_CH;
			irr_q     <= 1'b0;
			pos_q     <= '0;
			pos_cap_q <= '0;
			hits_q    <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COLS:  cols_q <= cfg_data[12:0];
					CFG_ROWS:  rows_q <= cfg_data[12:0];
					CFG_CW:    cw_q   <= cfg_data;
					CFG_CH:    ch_q   <= cfg_data;
					CFG_IRREG: irr_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.acc && in_mode) begin
				hits_q    <= hits_d;
				pos_cap_q <= pos_q;
				if (in_final_byte) pos_q <= '0;
				else if (int'(pos_q) < POS_LIMIT) pos_q <= pos_q + PW'(1);
			end else if (cmd.emit) begin
				hits_q[cur_b] <= 1'b0;
			end
			if (cmd.div_start) div_cnt_q <= DIV_STEPS;
			else if (cmd.div_step) div_cnt_q <= div_cnt_q - 4'd1;
		end
	end

	// permutation memory
	always_ff @(posedge clk) begin
		if (cmd.acc && !in_mode && (int'(in_perm_address) < MAX_CELLS))
			mem[AW'(in_perm_address)] <= in_perm_value;
		if (cmd.rd) rd_q <= mem[AW'(idx_b)];
	end

	// restoring divider, cell / columns
	assign shifted = {rem_q, quo_q[CELL_W-1]};
	assign ge      = shifted >= {1'b0, cols_q};

	assign ta_col = {20'b0, rem_q[11:0]} * HASH_C1;
	assign ta_row = {20'b0, quo_q} * HASH_C2;
	assign ht     = ta_q ^ (cmd.axis_y ? SALT_Y : SALT_X);
	assign ht2    = ht ^ (ht >> 13);
	assign hm_d   = ht2 * HASH_C3;
	assign hx     = hm_q ^ (hm_q >> 16);
	assign sc     = {14'b0, hx[19:0]} * OFF_SCALE;
	assign off_d  = irr_q ? (OFF_BASE + {2'b0, sc[33:20]}) : OFF_MID;
	assign q16    = {cmd.axis_y ? quo_q : rem_q[11:0], off_q};
	assign pp     = {16'b0, q16} * {28'b0, cmd.axis_y ? ch_q : cw_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= rd_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? 13'(shifted - {1'b0, cols_q}) : shifted[12:0];
			quo_q <= {quo_q[CELL_W-2:0], ge};
		end
		if (cmd.ha) ta_q <= ta_col;
		if (cmd.hb) ta_q <= ta_q ^ ta_row;
		if (cmd.hc) hm_q <= hm_d;
		if (cmd.hd) off_q <= off_d;
		if (cmd.pl && !cmd.axis_y) px_q <= pp[43:16];
		if (cmd.pl && cmd.axis_y) py_q <= pp[43:16];
		if (cmd.emit) begin
			centre_x    <= px_q;
			centre_y    <= py_q;
			cell_column <= rem_q[11:0];
			cell_row    <= quo_q;
			run_end     <= stat.last_hit;
		end
	end
endmodule
`default_nettype wire

@@ bench/bits_to_hashed_grid_centers_top_tb.sv @@
// testbench for bits_to_hashed_grid_centers_top: scoreboard prediction of cell centres
`timescale 1ns / 100ps
`default_nettype none
module bits_to_hashed_grid_centers_top_tb;
	import b2hgc_pkg::*;

	localparam logic MODE_PERM = 1'b0;
	localparam logic MODE_BYTE = 1'b1;
	localparam int TABLE_DEPTH = 4096;
	localparam int POS_SATURATE = TABLE_DEPTH / 8;
	localparam int FILLED_ENTRIES = 32;
	localparam int LAST_BYTE_POS = FILLED_ENTRIES / 8 - 1;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [27:0] x;
		logic [27:0] y;
		logic [11:0] col;
		logic [11:0] row;
		logic        last;
	} centre_t;

	class centre_scoreboard;
		logic [11:0] perm_table [TABLE_DEPTH];
		int unsigned position;
		logic [12:0] columns;
		logic [12:0] rows;
		logic [15:0] width;
		logic [15:0] height;
		logic        irregular;
		centre_t     centres_due [$];
		int          errors;

		function new();
			position = 0;
			columns = RST_COLS;
			rows = RST_ROWS;
			width = RST_CW;
			height = RST_CH;
			irregular = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_COLS: columns = value[12:0];
				CFG_ROWS: rows = value[12:0];
				CFG_CW: width = value;
				CFG_CH: height = value;
				CFG_IRREG: irregular = value[0];
				default: ;
			endcase
		endfunction

		function logic [15:0] axis_offset(logic [31:0] c, logic [31:0] r, logic [31:0] salt);
			logic [31:0] h;
			logic [63:0] scaled;
			if (!irregular) return OFF_MID;
			h = (c * HASH_C1) ^ (r * HASH_C2) ^ (salt * HASH_C3);
			h = (h ^ (h >> 13)) * HASH_C3;
			h = h ^ (h >> 16);
			scaled = (64'(h[19:0]) * 64'd13107) >> 20;
			return OFF_BASE + scaled[15:0];
		endfunction

		function logic [27:0] coordinate(logic [11:0] idx, logic [15:0] off, logic [15:0] size);
			logic [63:0] q;
			q = (64'(idx) << 16) + 64'(off);
			q = (q * 64'(size)) >> 16;
			return q[27:0];
		endfunction

		function void note_input(logic mode, logic [11:0] addr, logic [11:0] value,
			logic [7:0] data, logic fin);
			int unsigned total;
			int unsigned idx;
			int          produced;
			logic [12:0] cell_idx;
			logic [12:0] col;
			logic [12:0] row;
			centre_t     c;
			produced = 0;
			if (mode == MODE_PERM) begin
				perm_table[addr] = value;
				return;
			end
			total = int'(columns) * int'(rows);
			if (total > TABLE_DEPTH) total = TABLE_DEPTH;
			for (int b = 0; b < 8; b++) begin
				idx = position * 8 + b;
				if (data[7-b] && idx < total) begin
					cell_idx = {1'b0, perm_table[idx]};
					col = cell_idx % columns;
					row = cell_idx / columns;
					c.x = coordinate(col[11:0], axis_offset(32'(col), 32'(row), 32'd1), width);
					c.y = coordinate(row[11:0], axis_offset(32'(col), 32'(row), 32'd2), height);
					c.col = col[11:0];
					c.row = row[11:0];
					c.last = 1'b0;
					centres_due = {centres_due, c};
					produced++;
				end
			end
			if (produced > 0) centres_due[centres_due.size()-1].last = 1'b1;
			if (fin) position = 0;
			else if (position < POS_SATURATE) position++;
		endfunction

		function void check_result(centre_t got);
			centre_t want;
			if (centres_due.size() == 0) begin
				errors++;
				$error("unexpected centre transaction x=%0d y=%0d", got.x, got.y);
				return;
			end
			want = centres_due.pop_front();
			if (got.x !== want.x) begin
				errors++;
				$error("centre_x expected %0d actual %0d", want.x, got.x);
			end
			if (got.y !== want.y) begin
				errors++;
				$error("centre_y expected %0d actual %0d", want.y, got.y);
			end
			if (got.col !== want.col) begin
				errors++;
				$error("cell_column expected %0d actual %0d", want.col, got.col);
			end
			if (got.row !== want.row) begin
				errors++;
				$error("cell_row expected %0d actual %0d", want.row, got.row);
			end
			if (got.last !== want.last) begin
				errors++;
				$error("run_end expected %0d actual %0d", want.last, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int in_idle_pct;
	int out_idle_pct;
	int stall_cycles;

	b2hgc_in_if in_ch();
	b2hgc_out_if out_ch();
	centre_scoreboard centres;

	bits_to_hashed_grid_centers_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(negedge clk) begin
		out_ch.ready = ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		centre_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.x = out_ch.centre_x;
			got.y = out_ch.centre_y;
			got.col = out_ch.cell_column;
			got.row = out_ch.cell_row;
			got.last = out_ch.run_end;
			centres.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_item(logic mode, logic [11:0] addr, logic [11:0] value,
		logic [7:0] data, logic fin);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.mode = mode;
		in_ch.perm_address = addr;
		in_ch.perm_value = value;
		in_ch.data_byte = data;
		in_ch.final_byte = fin;
		do @(posedge clk); while (!in_ch.ready);
		centres.note_input(mode, addr, value, data, fin);
	endtask

	task automatic send_byte(logic [7:0] data, logic fin);
		send_item(MODE_BYTE, 12'($urandom), 12'($urandom), data, fin);
	endtask

	task automatic send_perm(logic [11:0] addr, logic [11:0] value);
		send_item(MODE_PERM, addr, value, 8'($urandom), 1'($urandom));
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (centres.centres_due.size() != 0 || !in_ch.ready) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		centres.write_reg(idx, value);
	endtask

	task automatic set_grid(int cols, int rows_n, int cw, int ch, logic irreg);
		wait_quiet();
		write_reg(CFG_COLS, 16'(cols));
		write_reg(CFG_ROWS, 16'(rows_n));
		write_reg(CFG_CW, 16'(cw));
		write_reg(CFG_CH, 16'(ch));
		write_reg(CFG_IRREG, 16'(irreg));
	endtask

	// messages end early so bytes only reach the filled table entries
	task automatic random_items(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 20)
				send_perm(12'($urandom), 12'($urandom));
			else
				send_byte(8'($urandom), ($urandom_range(5) == 0)
					|| (centres.position >= LAST_BYTE_POS));
		end
	endtask

	initial begin
		centres = new();
		in_idle_pct = 0;
		out_idle_pct = 0;
		stall_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_PERM;
		in_ch.perm_address = '0;
		in_ch.perm_value = '0;
		in_ch.data_byte = '0;
		in_ch.final_byte = 1'b0;
		out_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// table entries that bytes can reach get written first
		for (int a = 0; a < FILLED_ENTRIES; a++) send_perm(12'(a), 12'($urandom));

		// reset settings
		send_byte(8'hFF, 1'b0);
		send_byte(8'h81, 1'b1);
		send_perm(12'd0, 12'hFFF);
		send_perm(12'hFFF, 12'd0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h00, 1'b1);

		set_grid(4096, 1, 65535, 0, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hAA, 1'b1);

		set_grid(1, 4096, 0, 65535, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b1);

		// small grid: most bit indexes fall outside it
		set_grid(3, 2, 65535, 65535, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);

		// no cells at all
		set_grid(0, 4096, 256, 256, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);

		// grid larger than the table
		set_grid(4096, 4096, 300, 700, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hC0, 1'b1);

		in_idle_pct = 6;
		out_idle_pct = 84;
		set_grid(5, 7, $urandom_range(65535), $urandom_range(65535), 1'b1);
		random_items(20);

		in_idle_pct = 84;
		out_idle_pct = 6;
		set_grid(64, 64, $urandom_range(65535), $urandom_range(65535), 1'b0);
		random_items(20);

		in_idle_pct = 0;
		out_idle_pct = 0;
		set_grid($urandom_range(1, 4096), $urandom_range(1, 64), $urandom_range(65535),
			$urandom_range(65535), 1'b1);
		random_items(20);

		wait_quiet();
		if (centres.errors == 0 && centres.centres_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/b2hgc_pkg.sv
rtl/b2hgc_if.sv
rtl/b2hgc_ctrl.sv
rtl/b2hgc_dp.sv
rtl/bits_to_hashed_grid_centers_top.sv
bench/bits_to_hashed_grid_centers_top_tb.sv
